[rtl/c_subset_lexer_unit_defines.svh]
// assertion macros for the c subset lexer
// no dependencies; included by files that carry assertions
`ifndef C_SUBSET_LEXER_UNIT_DEFINES_SVH
`define C_SUBSET_LEXER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CLU_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer check failed");
`define CLU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer check failed");
`else
`define CLU_ASSERT_NOW(name, clk, rst, ante, cons)
`define CLU_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[rtl/clu_pkg.sv]
// shared types, constants and keyword tables of the c subset lexer
// no dependencies
package clu_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int OFFSET_BITS = 32;

   localparam int CHAR_W  = 8;
   localparam int KIND_W  = 3;
   localparam int START_W = 32;
   localparam int LEN_W   = 16;

   localparam int NUM_KW    = 3;
   localparam int KW_CHARS  = 8;
   localparam int POS_W     = 4;
   localparam int POS_LIMIT = 8;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      TOK_INTEGER  = 3'd0,
      TOK_IDENT    = 3'd1,
      TOK_OPERATOR = 3'd2,
      TOK_KEYWORD  = 3'd3,
      TOK_UNKNOWN  = 3'd4
   } tok_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_DIGITS = 3'b010,
      MODE_WORD   = 3'b100
   } lex_mode_type;

   typedef struct packed {
      tok_kind_type          kind;
      logic [START_W-1:0]    start;
      logic [LEN_W-1:0]      length;
      logic [CHAR_W-1:0]     first;
      logic                  last;
   } token_type;

   localparam logic [POS_W-1:0] KW_LEN [NUM_KW] = '{4'd3, 4'd6, 4'd5};

   localparam logic [CHAR_W-1:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"p", "r", "i", "n", "t", "f", 8'h00, 8'h00},
      '{"s", "c", "a", "n", "f", 8'h00, 8'h00, 8'h00}
   };

   // bit k set when c is character pos of keyword k
   function automatic logic [NUM_KW-1:0] kw_match(input logic [POS_W-1:0] pos,
                                                  input logic [CHAR_W-1:0] c);
      logic [NUM_KW-1:0] hit;
      hit = '0;
      for (int k = 0; k < NUM_KW; k++) begin
         hit[k] = (pos < KW_LEN[k]) && (KW_TEXT[k][pos[2:0]] == c);
      end
      return hit;
   endfunction

endpackage

[rtl/clu_req_if.sv]
// request channel of the c subset lexer: one source byte per request
// depends on clu_pkg
interface clu_req_if;
   logic                       valid;
   logic                       ready;
   logic [clu_pkg::CHAR_W-1:0] ch;
   logic                       end_of_text;

   modport source (output valid, ch, end_of_text, input ready);
   modport sink   (input valid, ch, end_of_text, output ready);
endinterface

[rtl/clu_rsp_if.sv]
// result channel of the c subset lexer: one token per transfer
// depends on clu_pkg
interface clu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [clu_pkg::KIND_W-1:0]  token_type;
   logic [clu_pkg::START_W-1:0] token_start;
   logic [clu_pkg::LEN_W-1:0]   token_length;
   logic [clu_pkg::CHAR_W-1:0]  first_char;
   logic                        run_last;

   modport source (output valid, token_type, token_start, token_length, first_char,
                   run_last, input ready);
   modport sink   (input valid, token_type, token_start, token_length, first_char,
                   run_last, output ready);
endinterface

[rtl/c_subset_lexer_unit.sv]
// c subset lexer top level: byte-serial tokenizer with a four-entry token queue
// depends on clu_pkg, clu_req_if, clu_rsp_if and c_subset_lexer_unit_defines.svh
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    ch, end_of_text
//   rsp      out  valid / ready    token_type, token_start, token_length,
//                                  first_char, run_last
//
// one request is taken per cycle while the token queue has two free entries
// a request yields zero, one or two tokens; the rsp side drains one per cycle while rsp.ready is high
// with the queue empty, the first token is visible the cycle after the request is accepted
// synchronous reset clears the run state and byte offset and empties the token queue
// rsp stalls back up into req once the queue holds more than two tokens
`include "c_subset_lexer_unit_defines.svh"

module c_subset_lexer_unit (
   input logic      clock,
   input logic      reset,
   clu_req_if.sink  req,
   clu_rsp_if.source rsp
);

   localparam logic [clu_pkg::LENGTH_BITS-1:0] LEN_ONE   = clu_pkg::LENGTH_BITS'(1);
   localparam logic [clu_pkg::LENGTH_BITS-1:0] LEN_POS   =
      clu_pkg::LENGTH_BITS'(clu_pkg::POS_LIMIT);

   // run state
   clu_pkg::lex_mode_type                mode_ff, mode_in;
   logic [clu_pkg::OFFSET_BITS-1:0]      offset_ff, offset_in;
   logic [clu_pkg::OFFSET_BITS-1:0]      start_ff, start_in;
   logic [clu_pkg::LENGTH_BITS-1:0]      len_ff, len_in;
   logic [clu_pkg::CHAR_W-1:0]           first_ff, first_in;
   logic [clu_pkg::NUM_KW-1:0]           alive_ff, alive_in;

   // token queue
   clu_pkg::token_type                   queue_ff [clu_pkg::FIFO_DEPTH];
   logic [clu_pkg::PTR_BITS-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [clu_pkg::PTR_BITS-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [clu_pkg::CNT_BITS-1:0]         cnt_ff, cnt_in;

   logic                                 accept;
   logic                                 pop;
   logic [1:0]                           n_tok;
   clu_pkg::token_type                   tok_a, tok_b;

   logic [clu_pkg::CHAR_W-1:0]           c;
   logic                                 is_dig, is_let, is_sp, is_op;
   logic [clu_pkg::POS_W-1:0]            pos;

   function automatic clu_pkg::tok_kind_type run_kind(
      input clu_pkg::lex_mode_type             m,
      input logic [clu_pkg::NUM_KW-1:0]        al,
      input logic [clu_pkg::LENGTH_BITS-1:0]   ln);
      clu_pkg::tok_kind_type kd;
      kd = clu_pkg::TOK_INTEGER;
      if (m == clu_pkg::MODE_WORD) begin
         kd = clu_pkg::TOK_IDENT;
         for (int k = 0; k < clu_pkg::NUM_KW; k++) begin
            if (al[k] && ln == clu_pkg::LENGTH_BITS'(clu_pkg::KW_LEN[k])) begin
               kd = clu_pkg::TOK_KEYWORD;
            end
         end
      end
      return kd;
   endfunction

   assign accept = req.valid && req.ready;
   assign pop    = rsp.valid && rsp.ready;
   assign req.ready = cnt_ff <= clu_pkg::CNT_BITS'(clu_pkg::FIFO_DEPTH - 2);

   assign c      = req.ch;
   assign is_dig = (c >= "0") && (c <= "9");
   assign is_let = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   assign is_sp  = (c == " ") || (c == 8'h09) || (c == 8'h0a);
   assign is_op  = (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
                   (c == "<") || (c == ">") || (c == "=") || (c == "!") || (c == "&") ||
                   (c == "|");
   assign pos    = (len_ff < LEN_POS) ? len_ff[clu_pkg::POS_W-1:0]
                                      : clu_pkg::POS_W'(clu_pkg::POS_LIMIT);

   // per-byte token logic
   always_comb begin
      clu_pkg::token_type t;
      logic               taken;
      mode_in   = mode_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      alive_in  = alive_ff;
      offset_in = offset_ff;
      n_tok     = 2'd0;
      tok_a     = '0;
      tok_b     = '0;
      t         = '0;
      taken     = 1'b0;

      if (accept) begin
         offset_in = offset_ff + clu_pkg::OFFSET_BITS'(1);
         if (mode_ff == clu_pkg::MODE_DIGITS && is_dig) begin
            taken = 1'b1;
         end else if (mode_ff == clu_pkg::MODE_WORD && (is_let || is_dig)) begin
            taken    = 1'b1;
            alive_in = alive_ff & clu_pkg::kw_match(pos, c);
         end

         if (taken) begin
            if (len_ff != '1) begin
               len_in = len_ff + LEN_ONE;
            end
         end else begin
            if (mode_ff != clu_pkg::MODE_IDLE) begin
               t.kind   = run_kind(mode_ff, alive_ff, len_ff);
               t.start  = clu_pkg::START_W'(start_ff);
               t.length = clu_pkg::LEN_W'(len_ff);
               t.first  = first_ff;
               t.last   = 1'b0;
               tok_a    = t;
               n_tok    = 2'd1;
            end
            mode_in  = clu_pkg::MODE_IDLE;
            alive_in = '0;
            if (is_dig || is_let) begin
               mode_in  = is_dig ? clu_pkg::MODE_DIGITS : clu_pkg::MODE_WORD;
               start_in = offset_ff;
               len_in   = LEN_ONE;
               first_in = c;
               alive_in = is_let ? clu_pkg::kw_match('0, c) : '0;
            end else if (!is_sp) begin
               t.kind   = is_op ? clu_pkg::TOK_OPERATOR : clu_pkg::TOK_UNKNOWN;
               t.start  = clu_pkg::START_W'(offset_ff);
               t.length = clu_pkg::LEN_W'(LEN_ONE);
               t.first  = c;
               t.last   = 1'b0;
               if (n_tok == 2'd0) tok_a = t;
               else               tok_b = t;
               n_tok = n_tok + 2'd1;
            end
         end

         // end of text flushes the pending run
         if (req.end_of_text && mode_in != clu_pkg::MODE_IDLE) begin
            t.kind   = run_kind(mode_in, alive_in, len_in);
            t.start  = clu_pkg::START_W'(start_in);
            t.length = clu_pkg::LEN_W'(len_in);
            t.first  = first_in;
            t.last   = 1'b0;
            if (n_tok == 2'd0) tok_a = t;
            else               tok_b = t;
            n_tok    = n_tok + 2'd1;
            mode_in  = clu_pkg::MODE_IDLE;
            alive_in = '0;
         end

         if (n_tok == 2'd1) tok_a.last = 1'b1;
         if (n_tok == 2'd2) tok_b.last = 1'b1;
      end
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + clu_pkg::PTR_BITS'(n_tok);
      rd_ptr_in = pop ? rd_ptr_ff + clu_pkg::PTR_BITS'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + clu_pkg::CNT_BITS'(n_tok) - clu_pkg::CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= clu_pkg::MODE_IDLE;
         offset_ff <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         first_ff  <= '0;
         alive_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         first_ff  <= first_in;
         alive_ff  <= alive_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_tok != 2'd0) begin
         queue_ff[wr_ptr_ff] <= tok_a;
      end
      if (n_tok == 2'd2) begin
         queue_ff[wr_ptr_ff + clu_pkg::PTR_BITS'(1)] <= tok_b;
      end
   end

   assign rsp.valid        = cnt_ff != '0;
   assign rsp.token_type   = queue_ff[rd_ptr_ff].kind;
   assign rsp.token_start  = queue_ff[rd_ptr_ff].start;
   assign rsp.token_length = queue_ff[rd_ptr_ff].length;
   assign rsp.first_char   = queue_ff[rd_ptr_ff].first;
   assign rsp.run_last     = queue_ff[rd_ptr_ff].last;

   `CLU_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, cnt_ff <= clu_pkg::CNT_BITS'(clu_pkg::FIFO_DEPTH))
   `CLU_ASSERT_NOW(a_idle_no_kw, clock, reset, mode_ff == clu_pkg::MODE_IDLE, alive_ff == '0)
   `CLU_ASSERT_NOW(a_run_nonempty, clock, reset, mode_ff != clu_pkg::MODE_IDLE, len_ff != '0)
   `CLU_ASSERT_NEXT(a_offset_step, clock, reset, accept, offset_ff == $past(offset_ff) + clu_pkg::OFFSET_BITS'(1))

endmodule
